### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/smrg_pkg.sv
package smrg_pkg;

	// Field widths
	localparam int GRAD_W = 16;
	localparam int PROB_W = 16;
	localparam int LEN_W  = 7;
	localparam int DOT_W  = 40;
	localparam int DIFF_W = 41;
	localparam int PROD_W = 58;
	localparam int ENTRY_W = GRAD_W + PROB_W;

	localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 7'd64;

	// Round-half-up bias for the Q14.44 -> Q4.12 reduction
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = 58'sd2147483648;
	localparam logic signed [PROD_W-33:0] SAT_HI = 26'sd32767;
	localparam logic signed [PROD_W-33:0] SAT_LO = -26'sd32768;

	// One finished row waiting for the back end
	typedef struct packed {
		logic                    bank;
		logic [LEN_W-1:0]        len;
		logic signed [DOT_W-1:0] dot;
	} row_job_t;

	// Job queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} job_status_t;

endpackage

### src/smrg_job_fifo.sv
`include "assert_macros.svh"

module smrg_job_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smrg_pkg::row_job_t  push_job,
	input  logic                pop,
	output smrg_pkg::row_job_t  head_job,
	output smrg_pkg::job_status_t status
);
	import smrg_pkg::*;

	localparam int DEPTH = 2;

	row_job_t   slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Job slots
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	assign head_job     = slot_q[rd_ptr_q];
	assign status.full  = (count_q == 2'(DEPTH));
	assign status.empty = (count_q == 2'd0);

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && status.full))
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(pop && status.empty))
	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= 2'(DEPTH))

endmodule

### src/smrg_front.sv
`include "assert_macros.svh"

module smrg_front #(
	parameter int MAX_ROW = 64,
	parameter int AW      = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [smrg_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,
	input  smrg_pkg::job_status_t         status,
	output logic                          push,
	output smrg_pkg::row_job_t            push_job,
	output logic                          wr_en,
	output logic [AW:0]                   wr_addr,
	output logic [smrg_pkg::ENTRY_W-1:0]  wr_data
);
	import smrg_pkg::*;

	logic [LEN_W-1:0]        row_length_q;
	logic [LEN_W-1:0]        count_q;
	logic signed [DOT_W-1:0] dot_q;
	logic                    bank_q;

	logic signed [GRAD_W-1:0] grad;
	logic [PROB_W-1:0]        prob;
	logic [AW-1:0]            idx;
	logic [LEN_W-1:0]         n;
	logic [LEN_W-1:0]         eff_len;
	logic signed [DOT_W-1:0]  gp;
	logic signed [DOT_W-1:0]  dot_next;
	logic                     accept;
	logic                     row_done;

	assign grad = s_tdata[GRAD_W-1:0];
	assign prob = s_tdata[GRAD_W +: PROB_W];

	// Accept while the back end still has a free row bank
	assign s_tready = !status.full;
	assign accept   = s_tvalid && s_tready;

	// Effective row length: zero means one, cap at MAX_ROW
	always_comb begin
		if (row_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (row_length_q > LEN_W'(MAX_ROW)) begin
			eff_len = LEN_W'(MAX_ROW);
		end else begin
			eff_len = row_length_q;
		end
	end

	// Slot index, product and running dot
	always_comb begin
		if (count_q >= LEN_W'(MAX_ROW)) begin
			idx = AW'(MAX_ROW - 1);
		end else begin
			idx = count_q[AW-1:0];
		end
		n        = LEN_W'(idx) + LEN_W'(1);
		gp       = grad * $signed({1'b0, prob});
		dot_next = dot_q + gp;
		row_done = (n >= eff_len);
	end

	assign wr_en   = accept;
	assign wr_addr = {bank_q, idx};
	assign wr_data = {prob, grad};

	assign push          = accept && row_done;
	assign push_job.bank = bank_q;
	assign push_job.len  = n;
	assign push_job.dot  = dot_next;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
		end else if (cfg_we) begin
			row_length_q <= cfg_wdata;
		end
	end

	// Row accumulation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dot_q   <= '0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (row_done) begin
				count_q <= '0;
				dot_q   <= '0;
				bank_q  <= ~bank_q;
			end else begin
				count_q <= n;
				dot_q   <= dot_next;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_below_max, clk, arst_n, count_q < LEN_W'(MAX_ROW))
	`ASSERT_NEXT(a_push_clears_row, clk, arst_n, push, count_q == '0 && dot_q == '0)
	`ASSERT_NEXT(a_bank_toggles, clk, arst_n, push, bank_q != $past(bank_q))

endmodule

### src/smrg_back.sv
module smrg_back #(
	parameter int AW      = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [AW:0]                   wr_addr,
	input  logic [smrg_pkg::ENTRY_W-1:0]  wr_data,
	input  smrg_pkg::row_job_t            head_job,
	input  smrg_pkg::job_status_t         status,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,
	output logic                          m_tlast
);
	import smrg_pkg::*;

	localparam int DEPTH = 2 * (1 << AW);

	// Two row banks, selected by the top address bit
	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [AW-1:0] k_q;
	logic          adv;
	logic          issue;
	logic          last_issue;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [ENTRY_W-1:0]       entry_s1;
	logic signed [DOT_W-1:0]  dot_s1;
	logic [PROB_W-1:0]        prob_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [PROD_W-1:0] prod_s3;

	logic                      out_valid_q;
	logic                      out_last_q;
	logic [GRAD_W-1:0]         out_data_q;

	logic signed [DIFF_W-1:0]    diff;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    biased;
	logic signed [PROD_W-33:0]   rounded;
	logic [GRAD_W-1:0]           sat;

	// Whole pipeline moves when the output slot frees
	assign adv        = !out_valid_q || m_tready;
	assign issue      = adv && !status.empty;
	assign last_issue = (LEN_W'(k_q) + LEN_W'(1)) >= head_job.len;
	assign pop        = issue && last_issue;

	// Row bank storage
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (issue) entry_s1 <= mem[{head_job.bank, k_q}];
	end

	// Read index walks the head row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= last_issue ? '0 : k_q + AW'(1);
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Datapath: difference, product, round and saturate
	always_comb begin
		diff    = $signed({entry_s1[GRAD_W-1:0], 16'b0}) - dot_s1;
		prod    = $signed({1'b0, prob_s2}) * diff_s2;
		biased  = prod_s3 + ROUND_BIAS;
		rounded = biased[PROD_W-1:32];
		if (rounded > SAT_HI) begin
			sat = 16'h7FFF;
		end else if (rounded < SAT_LO) begin
			sat = 16'h8000;
		end else begin
			sat = rounded[GRAD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1    <= last_issue;
			dot_s1     <= head_job.dot;
			last_s2    <= last_s1;
			prob_s2    <= entry_s1[ENTRY_W-1:GRAD_W];
			diff_s2    <= diff;
			last_s3    <= last_s2;
			prod_s3    <= prod;
			out_last_q <= last_s3;
			out_data_q <= sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### src/softmax_row_gradient_top.sv
// Channel   Dir  tdata (low bit up)                       tuser/tlast
// s_*       in   [15:0] upstream_grad, [31:16] prob        -
// m_*       out  [15:0] input_grad                         tlast = row_last
// cfg_*     in   [6:0] row_length, taken when cfg_we high  -
//
// One item is taken per cycle while s_tready is high; a finished row of n items
// leaves one result per cycle by the read-multiply-round pipeline unless stalled.
// Two row banks let the next row load while the previous one drains.
// arst_n clears control state; row_length resets to 64. s_tready drops while both
// banks are busy; m_tready low freezes the back pipeline while m_tvalid is high.
module softmax_row_gradient_top #(
	parameter int MAX_ROW = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,  // row_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [15:0] upstream_grad, [31:16] prob
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] input_grad
	output logic        m_tlast
);
	import smrg_pkg::*;

	localparam int AW = $clog2(MAX_ROW);

	logic               push;
	row_job_t           push_job;
	logic               pop;
	row_job_t           head_job;
	job_status_t        status;
	logic               wr_en;
	logic [AW:0]        wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	smrg_front #(.MAX_ROW(MAX_ROW), .AW(AW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.status   (status),
		.push     (push),
		.push_job (push_job),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	smrg_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.status  (status)
	);

	smrg_back #(.AW(AW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.head_job(head_job),
		.status  (status),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
